// ----- rtl/core/scfla_pkg.sv -----
// Shared types, constants and size-class functions for the slab allocator.
package scfla_pkg;

  localparam int ArenaBytes = 65536;
  localparam int NumArenas  = 4;
  localparam int NumClasses = 56;
  localparam int AddrW      = 18;
  localparam int ClassW     = 6;
  localparam int BytesW     = 13;
  localparam int LinkW      = AddrW + 1;
  localparam int LinkDepth  = 32768;
  localparam int LinkIdxW   = 15;
  localparam int MaxSize    = 4096;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_MEMORY = 3'd3,
    ST_DBL_FREE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_SEND = 2'd2
  } bk_state_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    cmd_t               cmd;
    logic               reject;
    status_t            status;
    logic [ClassW-1:0]  cls;
    logic [BytesW-1:0]  bytes;
    logic [AddrW-1:0]   addr;
  } job_t;

  typedef struct packed {
    logic [AddrW-1:0]  granted_address;
    logic [ClassW-1:0] size_class;
    logic [BytesW-1:0] granted_bytes;
    status_t           status;
  } result_t;

  function automatic logic [ClassW-1:0] class_of(input logic [15:0] size);
    logic [11:0] s;
    logic [ClassW-1:0] c;
    s = 12'(size - 16'd1);
    if (s < 12'h080)      c = ClassW'(s >> 3);
    else if (s < 12'h100) c = ClassW'((s >> 4) + 12'd8);
    else if (s < 12'h200) c = ClassW'((s >> 5) + 12'd16);
    else if (s < 12'h400) c = ClassW'((s >> 6) + 12'd24);
    else if (s < 12'h800) c = ClassW'((s >> 7) + 12'd32);
    else                  c = ClassW'((s >> 8) + 12'd40);
    return c;
  endfunction

  function automatic logic [BytesW-1:0] class_bytes(input logic [ClassW-1:0] c);
    logic [6:0] i;
    logic [BytesW-1:0] b;
    i = (c < ClassW'(NumClasses)) ? 7'(c) + 7'd1 : 7'(c - ClassW'(NumClasses)) + 7'd1;
    if (i <= 7'd16)      b = BytesW'(i) << 3;
    else if (i <= 7'd24) b = BytesW'(i - 7'd8) << 4;
    else if (i <= 7'd32) b = BytesW'(i - 7'd16) << 5;
    else if (i <= 7'd40) b = BytesW'(i - 7'd24) << 6;
    else if (i <= 7'd48) b = BytesW'(i - 7'd32) << 7;
    else                 b = BytesW'(i - 7'd40) << 8;
    return b;
  endfunction

endpackage

// ----- rtl/core/scfla_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
module scfla_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/scfla_front.sv -----
// Front end: classifies each request and queues it for the back end.
module scfla_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic [15:0]         in_size,
  input  logic [17:0]         in_addr,
  output logic                job_valid,
  input  logic                job_ready,
  output scfla_pkg::job_t     job
);
  import scfla_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  job_t            queue [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  job_t            cls_job;
  logic            push;
  logic            pop;

  always_comb begin
    cls_job        = '0;
    cls_job.cmd    = cmd_t'(in_cmd);
    cls_job.addr   = in_addr;
    cls_job.status = ST_OK;
    if (in_cmd == CMD_ALLOC || in_cmd == CMD_FREE) begin
      if (in_size == 16'd0) begin
        cls_job.reject = 1'b1;
        cls_job.status = ST_ZERO;
      end else if (in_size > 16'(MaxSize)) begin
        cls_job.reject = 1'b1;
        cls_job.status = ST_TOO_LARGE;
      end else begin
        cls_job.cls   = class_of(in_size);
        cls_job.bytes = class_bytes(class_of(in_size));
      end
    end
  end

  assign in_ready  = (count != (PtrW+1)'(QueueDepth));
  assign job_valid = (count != '0);
  assign job       = queue[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls_job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + PtrW'(1);
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

// ----- rtl/core/scfla_back.sv -----
// Back end: free lists, carve cursors, arena ownership and the link memory.
module scfla_back #(
  parameter int ArenaBytesP = scfla_pkg::ArenaBytes,
  parameter int NumArenasP  = scfla_pkg::NumArenas
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         arena_limit,
  input  logic               job_valid,
  output logic               job_ready,
  input  scfla_pkg::job_t    job,
  output logic               res_valid,
  input  logic               res_ready,
  output scfla_pkg::result_t res
);
  import scfla_pkg::*;

  localparam int OffW   = $clog2(ArenaBytesP);
  localparam int ArenaW = (NumArenasP > 1) ? $clog2(NumArenasP) : 1;
  localparam int CntW   = $clog2(NumArenasP + 1);
  localparam int HiW    = AddrW - OffW;

  bk_state_t state, state_next;

  logic [NumClasses-1:0] head_vld;
  logic [NumClasses-1:0] curs_vld;
  logic [ClassW:0]   owner   [NumArenasP];
  logic [CntW-1:0]   claimed;
  job_t              cur;
  result_t           res_q;

  logic              link_we;
  logic [LinkW-1:0]  link_rdata;
  logic [AddrW-1:0]  head_rdata;
  logic [AddrW-1:0]  curs_rdata;
  logic              head_we;
  logic [AddrW-1:0]  head_wdata;
  logic              curs_we;
  logic [ClassW-1:0] tbl_raddr;
  logic              pop_commit;
  logic              carve;
  logic              claim;
  logic [LinkW-1:0]  head_c;
  logic [LinkW-1:0]  curs_c;
  logic [CntW-1:0]   limit;
  logic [OffW:0]     next_off;
  logic [LinkW-1:0]  next_cur;
  logic [AddrW-1:0]  carve_addr;
  logic [HiW:0]      q_arena;
  logic              q_hit;
  result_t           res_c;
  logic              do_pop;
  logic              take;

  // Head and cursor entries are read at the class of the request being taken,
  // so their data is ready in the read state.
  assign tbl_raddr = (state == BK_IDLE) ? job.cls : cur.cls;
  assign head_c = {head_vld[cur.cls], head_rdata};
  assign curs_c = {curs_vld[cur.cls], curs_rdata};
  assign limit  = (int'(arena_limit) < NumArenasP) ? CntW'(arena_limit)
                                                   : CntW'(NumArenasP);
  assign carve_addr = curs_c[LinkW-1] ? curs_c[AddrW-1:0]
                                      : AddrW'(claimed) << OffW;
  assign next_off = (OffW+1)'(carve_addr[OffW-1:0]) + (OffW+1)'(cur.bytes);
  assign next_cur = ((next_off + (OffW+1)'(cur.bytes)) > (OffW+1)'(ArenaBytesP))
                    ? '0 : {1'b1, AddrW'(carve_addr + AddrW'(cur.bytes))};
  assign q_arena  = (HiW+1)'(cur.addr >> OffW);
  assign q_hit    = (q_arena < (HiW+1)'(claimed)) && owner[ArenaW'(q_arena)][ClassW];

  assign take      = (state == BK_IDLE) && job_valid;
  assign job_ready = (state == BK_IDLE);
  assign do_pop    = (cur.cmd == CMD_ALLOC) && !cur.reject && head_c[LinkW-1];
  assign link_we   = (state == BK_READ) && (cur.cmd == CMD_FREE) && !cur.reject
                     && !(head_c[LinkW-1] && head_c[AddrW-1:0] == cur.addr);
  assign pop_commit = (state == BK_SEND) && res_ready && do_pop;
  assign carve      = (state == BK_READ) && !cur.reject && (cur.cmd == CMD_ALLOC)
                      && !head_c[LinkW-1] && (curs_c[LinkW-1] || claimed < limit);
  assign claim      = carve && !curs_c[LinkW-1];
  assign head_we    = !rst && (link_we || pop_commit);
  assign head_wdata = link_we ? cur.addr : link_rdata[AddrW-1:0];
  assign curs_we    = !rst && carve;

  scfla_ram #(.Width(LinkW), .Depth(LinkDepth)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (cur.addr[AddrW-1:3]),
    .wdata (head_c),
    .raddr (head_c[AddrW-1:3]),
    .rdata (link_rdata)
  );

  scfla_ram #(.Width(AddrW), .Depth(NumClasses)) u_heads (
    .clk   (clk),
    .we    (head_we),
    .waddr (cur.cls),
    .wdata (head_wdata),
    .raddr (tbl_raddr),
    .rdata (head_rdata)
  );

  scfla_ram #(.Width(AddrW), .Depth(NumClasses)) u_cursor (
    .clk   (clk),
    .we    (curs_we),
    .waddr (cur.cls),
    .wdata (next_cur[AddrW-1:0]),
    .raddr (tbl_raddr),
    .rdata (curs_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (job_valid) state_next = BK_READ;
      BK_READ: state_next = BK_SEND;
      BK_SEND: if (res_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    res_c = '0;
    res_c.status = cur.status;
    unique case (cur.cmd)
      CMD_ALLOC, CMD_FREE: begin
        if (!cur.reject) begin
          res_c.size_class    = cur.cls;
          res_c.granted_bytes = cur.bytes;
          if (cur.cmd == CMD_ALLOC) begin
            if (head_c[LinkW-1]) begin
              res_c.granted_address = head_c[AddrW-1:0];
            end else if (curs_c[LinkW-1] || claimed < limit) begin
              res_c.granted_address = carve_addr;
            end else begin
              res_c.status = ST_NO_MEMORY;
            end
          end else if (head_c[LinkW-1] && head_c[AddrW-1:0] == cur.addr) begin
            res_c.status = ST_DBL_FREE;
          end
        end
      end
      CMD_QUERY: begin
        if (q_hit) begin
          res_c.size_class    = owner[ArenaW'(q_arena)][ClassW-1:0];
          res_c.granted_bytes = class_bytes(owner[ArenaW'(q_arena)][ClassW-1:0]);
        end
      end
      default: res_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) cur <= job;
    if (state == BK_READ) res_q <= res_c;
    if (rst) begin
      state    <= BK_IDLE;
      claimed  <= '0;
      head_vld <= '0;
      curs_vld <= '0;
      for (int i = 0; i < NumArenasP; i++) owner[i] <= '0;
    end else begin
      state <= state_next;
      if (carve) curs_vld[cur.cls] <= next_cur[LinkW-1];
      if (claim) begin
        owner[ArenaW'(claimed)] <= {1'b1, cur.cls};
        claimed <= claimed + CntW'(1);
      end
      // The link read issued in the read state lands in the send state.
      if (link_we) begin
        head_vld[cur.cls] <= 1'b1;
      end else if (pop_commit) begin
        head_vld[cur.cls] <= link_rdata[LinkW-1];
      end
    end
  end

  assign res_valid = (state == BK_SEND);
  assign res       = res_q;
endmodule

// ----- rtl/core/size_class_free_list_allocator.sv -----
// Top level of the size-class free-list slab allocator.
// Requests arrive on the s_axis channel: tdata carries command, size_bytes and
// block_address from bit 0 up. Each request yields exactly one result on the
// m_axis channel: granted_address, size_class, granted_bytes and status.
// A front stage classifies the request into a size class and places it in a
// two-entry queue; the back stage owns the free-list heads, carve cursors,
// arena ownership and the 32768-entry link memory.
// The back stage takes a new request only once the last result is accepted. It
// takes the request and reads its head and cursor entries, then checks them and
// issues the link memory read, then presents the result and commits the popped
// link. The synchronous memory reads set these steps. With the back stage idle,
// a request passes the queue, the cur register and res_q before its result is valid.
// While the receiver holds m_axis_tready low, the result waits in its register
// and the queue keeps taking requests until it is full.
// Reset empties every free list, cursor and arena claim through valid bits and sets
// arena_limit to 4; no memory needs clearing since only written entries are read.
// Unchecked: the user writes arena_limit by cfg_we/cfg_wdata only while the block is idle.
module size_class_free_list_allocator #(
  parameter int ArenaBytesP = scfla_pkg::ArenaBytes,
  parameter int NumArenasP  = scfla_pkg::NumArenas
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // command[1:0], size_bytes[17:2], block_address[35:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // granted_address[17:0], size_class[23:18],
                                      // granted_bytes[36:24], status[39:37]
);
  import scfla_pkg::*;

  logic       [2:0] arena_limit;
  logic             job_valid;
  logic             job_ready;
  job_t             job;
  result_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_limit <= 3'd4;
    end else if (cfg_we) begin
      arena_limit <= cfg_wdata;
    end
  end

  scfla_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tdata[1:0]),
    .in_size   (s_axis_tdata[17:2]),
    .in_addr   (s_axis_tdata[35:18]),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  scfla_back #(.ArenaBytesP(ArenaBytesP), .NumArenasP(NumArenasP)) u_back (
    .clk         (clk),
    .rst         (rst),
    .arena_limit (arena_limit),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res         (res)
  );

  assign m_axis_tdata = {res.status, res.granted_bytes, res.size_class, res.granted_address};

  a_ok_sizes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[39:37] == ST_OK && m_axis_tdata[17:0] != 18'd0
      |-> m_axis_tdata[36:24] != 13'd0)
    else $error("granted address without a class size");
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[39:37] == ST_ZERO || m_axis_tdata[39:37] == ST_TOO_LARGE)
      |-> m_axis_tdata[36:0] == 37'd0)
    else $error("rejected request carries data");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
endmodule
